// ----- hdl/msta_pkg.sv -----
// shared types and constants of the multi-stream timestamp aligner
package msta_pkg;

   localparam int STAMP_W = 64;
   localparam int PRICE_W = 64;
   localparam int TOL_W   = 32;
   localparam int ENTRY_W = PRICE_W + STAMP_W;

   localparam logic [TOL_W-1:0] TOL_RESET = 32'd1000000;

   localparam logic OP_INGEST = 1'b0;
   localparam logic OP_ALIGN  = 1'b1;

   localparam logic [2:0] ST_ACCEPTED  = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_BAD       = 3'd2;
   localparam logic [2:0] ST_NOT_READY = 3'd3;
   localparam logic [2:0] ST_ALIGNED   = 3'd4;
   localparam logic [2:0] ST_DROPPED   = 3'd5;

   typedef struct packed {
      logic               operation;
      logic [3:0]         stream_number;
      logic [PRICE_W-1:0] price_word;
      logic [STAMP_W-1:0] time_stamp;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         out_stream;
      logic [PRICE_W-1:0] out_price;
      logic [STAMP_W-1:0] out_stamp;
      logic [STAMP_W-1:0] drift;
      logic               last;
   } rsp_type;

   // result handed from the sequencer to the output register
   typedef struct packed {
      logic    load;
      rsp_type data;
   } emit_type;

endpackage

// ----- hdl/multi_stream_timestamp_aligner_top.sv -----
// top level: tolerance register, output register and the aligner sequencer
//
// req channel: one word per item, ingest a tick into a stream fifo or align
// all stream heads. rsp channel: result words, the final one of an item has
// last set. csr port: a write of csr_wr_data sets the drift tolerance; only
// write it while no item is in flight.
// one item is worked on at a time; req_stall is low only between items.
// ingest, bad stream, full and not-ready: the item passes dispatch, then
// the response state loads its result word into the output register.
// align: the head stamps are read from the tick ram one stream a cycle,
// then the scan end, drift and decide states; each result word is a ram
// read, then an output load: STREAM_COUNT words when the drift is within
// tolerance, one dropped-tick word otherwise.
// reset clears all fifo pointers and fill counts, empties the output
// register and loads the tolerance with 1000000 ns; ram contents are kept.
// a stalled result holds in the output register; the sequencer waits until
// that register is taken before it loads the next result word.
module multi_stream_timestamp_aligner_top
   import msta_pkg::*;
#(
   parameter int STREAM_COUNT = 4,
   parameter int FIFO_DEPTH   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [TOL_W-1:0] csr_wr_data
);

   logic [TOL_W-1:0] tol_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic             out_free;
   emit_type         emit;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   msta_seq #(
      .STREAM_COUNT (STREAM_COUNT),
      .FIFO_DEPTH   (FIFO_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .tolerance (tol_ff),
      .out_free  (out_free),
      .emit      (emit)
   );

   always_ff @(posedge clock) begin
      if (emit.load) begin
         rsp_data_ff <= emit.data;
      end
      if (reset) begin
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
         if (emit.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/msta_ram.sv -----
// simple dual-port synchronous ram, one write and one registered read port
module msta_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/msta_seq.sv -----
// per-stream fifo bookkeeping and the ingest / align sequencer around the tick ram
module msta_seq
   import msta_pkg::*;
#(
   parameter int STREAM_COUNT = 4,
   parameter int FIFO_DEPTH   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  logic [TOL_W-1:0] tolerance,
   input  logic             out_free,
   output emit_type         emit
);

   localparam int SW    = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
   localparam int PW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW    = $clog2(FIFO_DEPTH + 1);
   localparam int DEPTH = STREAM_COUNT * (2 ** PW);
   localparam int AW    = SW + PW;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_SCAN_END,
      S_DRIFT,
      S_DECIDE,
      S_EMIT_RD,
      S_EMIT_WR,
      S_RESP
   } state_type;

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   rsp_type            pay_ff, pay_in;
   logic [PW-1:0]      head_ff [STREAM_COUNT];
   logic [PW-1:0]      head_in [STREAM_COUNT];
   logic [PW-1:0]      tail_ff [STREAM_COUNT];
   logic [PW-1:0]      tail_in [STREAM_COUNT];
   logic [CW-1:0]      fill_ff [STREAM_COUNT];
   logic [CW-1:0]      fill_in [STREAM_COUNT];
   logic [SW-1:0]      cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [SW-1:0]      pend_idx_ff, pend_idx_in;
   logic [STAMP_W-1:0] lo_ff, lo_in;
   logic [STAMP_W-1:0] hi_ff, hi_in;
   logic [SW-1:0]      lo_idx_ff, lo_idx_in;
   logic [STAMP_W-1:0] drift_ff, drift_in;
   logic               align_ff, align_in;

   logic               wr_en;
   logic               rd_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [STAMP_W-1:0] rd_stamp;
   logic [PRICE_W-1:0] rd_price;
   logic [SW-1:0]      sidx;
   logic               bad;
   logic               full;
   logic               any_empty;
   logic               last_stream;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      r = (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
      return r;
   endfunction

   msta_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({item_ff.price_word, item_ff.time_stamp}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_stamp    = rd_data[STAMP_W-1:0];
   assign rd_price    = rd_data[ENTRY_W-1:STAMP_W];
   assign sidx        = item_ff.stream_number[SW-1:0];
   assign bad         = {1'b0, item_ff.stream_number} >= 5'(STREAM_COUNT);
   assign full        = fill_ff[sidx] == CW'(FIFO_DEPTH);
   assign last_stream = cnt_ff == SW'(STREAM_COUNT - 1);
   assign wr_addr     = {sidx, tail_ff[sidx]};
   assign rd_addr     = {cnt_ff, head_ff[cnt_ff]};
   assign req_stall   = state_ff != S_IDLE;

   always_comb begin
      any_empty = 1'b0;
      for (int s = 0; s < STREAM_COUNT; s++) begin
         if (fill_ff[s] == '0) begin
            any_empty = 1'b1;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      pay_in      = pay_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      lo_idx_in   = lo_idx_ff;
      drift_in    = drift_ff;
      align_in    = align_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      emit.load   = 1'b0;

      emit.data.status     = align_ff ? ST_ALIGNED : ST_DROPPED;
      emit.data.out_stream = 4'(cnt_ff);
      emit.data.out_price  = rd_price;
      emit.data.out_stamp  = rd_stamp;
      emit.data.drift      = drift_ff;
      emit.data.last       = !align_ff || last_stream;
      if (state_ff == S_RESP) begin
         emit.data = pay_ff;
      end

      // min / max of the head stamps, one ram word per cycle
      if (pend_ff) begin
         if (pend_idx_ff == '0) begin
            lo_in     = rd_stamp;
            hi_in     = rd_stamp;
            lo_idx_in = '0;
         end else begin
            if (rd_stamp < lo_ff) begin
               lo_in     = rd_stamp;
               lo_idx_in = pend_idx_ff;
            end
            if (rd_stamp > hi_ff) begin
               hi_in = rd_stamp;
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            pay_in = '0;
            pay_in.last = 1'b1;
            state_in = S_RESP;
            if (item_ff.operation == OP_INGEST) begin
               if (bad) begin
                  pay_in.status = ST_BAD;
               end else if (full) begin
                  pay_in.status = ST_FULL;
               end else begin
                  pay_in.status = ST_ACCEPTED;
                  wr_en         = 1'b1;
                  tail_in[sidx] = ptr_next(tail_ff[sidx]);
                  fill_in[sidx] = fill_ff[sidx] + CW'(1);
               end
            end else if (any_empty) begin
               pay_in.status = ST_NOT_READY;
            end else begin
               cnt_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_en       = 1'b1;
            pend_in     = 1'b1;
            pend_idx_in = cnt_ff;
            if (last_stream) begin
               state_in = S_SCAN_END;
            end else begin
               cnt_in = cnt_ff + SW'(1);
            end
         end
         S_SCAN_END: begin
            state_in = S_DRIFT;
         end
         S_DRIFT: begin
            drift_in = hi_ff - lo_ff;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            align_in = drift_ff <= {32'b0, tolerance};
            cnt_in   = (drift_ff <= {32'b0, tolerance}) ? '0 : lo_idx_ff;
            state_in = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            rd_en    = 1'b1;
            state_in = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (out_free) begin
               emit.load       = 1'b1;
               head_in[cnt_ff] = ptr_next(head_ff[cnt_ff]);
               fill_in[cnt_ff] = fill_ff[cnt_ff] - CW'(1);
               if (!align_ff || last_stream) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + SW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               emit.load = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pay_ff      <= pay_in;
      cnt_ff      <= cnt_in;
      pend_idx_ff <= pend_idx_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      lo_idx_ff   <= lo_idx_in;
      drift_ff    <= drift_in;
      align_ff    <= align_in;
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         head_ff  <= '{default: '0};
         tail_ff  <= '{default: '0};
         fill_ff  <= '{default: '0};
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
      end
   end

endmodule
